/* rtl/estg_pkg.sv */
// Shared types, constants and helper functions for the enveloped sine tone generator.
// No dependencies; the result interface and all modules of the block import this package.
package estg_pkg;

  // Sizing
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int COUNT_BITS       = 20;
  localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
  localparam int PHASE_W          = 32;
  localparam int VOLUME_W         = 15;
  localparam int MAG_W            = 15;
  localparam int SAMPLE_W         = 16;
  localparam int ENV_PHASE_W      = 16;
  localparam int ENV_SHIFT        = PHASE_W - ENV_PHASE_W - 1;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_INDEX_W      = 2;

  // Arithmetic unit sizing
  localparam int MUL_A_W     = 2 * MAG_W;
  localparam int MUL_B_W     = MAG_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int SCALE_SHIFT = 30;
  localparam int DIVIDEND_W  = ((COUNT_BITS > ENV_PHASE_W) ? COUNT_BITS : ENV_PHASE_W) + 1;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

  localparam logic [MAG_W-1:0]      PEAK        = {MAG_W{1'b1}};
  localparam logic [DIVIDEND_W-1:0] ENV_ONE     = DIVIDEND_W'(1) << ENV_PHASE_W;
  localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_SAMPLE_COUNT = 2'd1,
    REG_VOLUME       = 2'd2
  } cfg_reg_t;

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_MUL      = 2'd1,
    OP_DIV_INIT = 2'd2,
    OP_DIV_STEP = 2'd3
  } arith_op_t;

  typedef struct packed {
    arith_op_t               op;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [DIVIDEND_W-1:0]   dividend;
    logic [COUNT_BITS-1:0]   divisor;
  } arith_ctl_t;

  typedef struct packed {
    logic [PROD_W-1:0]       product;
    logic [ENV_PHASE_W-1:0]  quotient;
    logic [COUNT_BITS-1:0]   remainder;
  } arith_res_t;

  // Quadrant and position of a phase within the quarter-wave table
  typedef struct packed {
    logic [1:0]             quad;
    logic [SINE_ADDR_W-1:0] pos;
  } sine_pt_t;

  typedef logic [MAG_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic sine_pt_t sine_point(input logic [PHASE_W-1:0] ph);
    return sine_pt_t'(ph[PHASE_W-1 -: SINE_ADDR_W+2]);
  endfunction

  // Odd quadrants run the table backwards; position zero there is the peak
  function automatic logic [SINE_ADDR_W-1:0] sine_addr(input sine_pt_t pt);
    return pt.quad[0] ? (SINE_ADDR_W'(0) - pt.pos) : pt.pos;
  endfunction

  function automatic logic sine_is_peak(input sine_pt_t pt);
    return pt.quad[0] && (pt.pos == '0);
  endfunction

  // One table entry: fixed-point Taylor series of sin, seven terms, Q30
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    if (sum < 64'sd0) begin
      sum = 64'sd0;
    end
    v = ((unsigned'(sum) * 64'(PEAK)) + (64'd1 << 29)) >> 30;
    if (v > 64'(PEAK)) begin
      v = 64'(PEAK);
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

endpackage

/* rtl/estg_req_if.sv */
// Request channel of the tone generator: valid/ready handshake plus restart flag.
// Standalone; no package dependencies.
interface estg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

/* rtl/estg_rsp_if.sv */
// Result channel of the tone generator: valid/ready handshake plus PCM sample and flags.
// Depends on estg_pkg for the sample width.
interface estg_rsp_if;
  import estg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

/* rtl/enveloped_sine_tone_generator_top.sv */
// Enveloped sine tone generator: one PCM sample per request, half-sine envelope.
// Playing request: table lookups, two multiplies and the 21-step envelope divider run in
// turn, then the result is registered once the output is free; ready rises in that same
// cycle, so no new request is accepted before the result. Request while idle (no tone):
// straight to the result, with a zero sample. One request in flight at a time.
// Synchronous active-high reset clears the tone state, config to defaults, output empty.
module enveloped_sine_tone_generator_top (
  input  logic                             clk,
  input  logic                             rst,
  estg_req_if.sink                         req,
  estg_rsp_if.source                       rsp,
  input  logic                             wr_en,
  input  logic [estg_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [estg_pkg::CFG_DATA_W-1:0]  wr_data
);
  import estg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b00000001,
    S_LOOK_TONE = 8'b00000010,
    S_LOOK_ENV  = 8'b00000100,
    S_MUL_VOL   = 8'b00001000,
    S_MUL_ENV   = 8'b00010000,
    S_DIV_INIT  = 8'b00100000,
    S_DIVIDE    = 8'b01000000,
    S_FINISH    = 8'b10000000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [PHASE_W-1:0]    phase_step;
  logic [COUNT_BITS-1:0] sample_count;
  logic [VOLUME_W-1:0]   volume;

  // Tone state
  logic                   running;
  logic [COUNT_BITS-1:0]  sample_index;
  logic [PHASE_W-1:0]     tone_phase;
  logic [ENV_PHASE_W-1:0] envelope_phase;
  logic [COUNT_BITS-1:0]  envelope_remainder;

  // Working registers
  logic                  look_peak;
  logic                  s_neg;
  logic [MAG_W-1:0]      s_mag;
  logic [MAG_W-1:0]      e_mag;
  logic [DIV_CNT_W-1:0]  div_cnt;

  // Output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       out_active;

  logic [SINE_ADDR_W-1:0] rom_addr;
  logic [MAG_W-1:0]       rom_q;
  arith_ctl_t             arith_ctl;
  arith_res_t             arith_res;

  sine_pt_t               tone_pt;
  sine_pt_t               env_pt;
  logic [COUNT_BITS-1:0]  n_eff;
  logic                   fin;
  logic                   out_free;
  logic [SAMPLE_W-1:0]    mag_ext;
  logic [SAMPLE_W-1:0]    pcm;

  // Table lookups for tone and envelope phases
  assign tone_pt  = sine_point(tone_phase);
  assign env_pt   = sine_point({1'b0, envelope_phase, {ENV_SHIFT{1'b0}}});
  assign rom_addr = (state == S_LOOK_TONE) ? sine_addr(tone_pt) : sine_addr(env_pt);

  // Tone length, zero treated as one
  assign n_eff = (sample_count == '0) ? COUNT_BITS'(1) : sample_count;
  assign fin   = ({1'b0, sample_index} + (COUNT_BITS+1)'(1)) >= {1'b0, n_eff};

  assign out_free = !out_valid || rsp.ready;

  // Scaled magnitude, sign restored (truncates toward zero)
  assign mag_ext = SAMPLE_W'(arith_res.product[SCALE_SHIFT +: MAG_W]);
  assign pcm     = s_neg ? (SAMPLE_W'(0) - mag_ext) : mag_ext;

  estg_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  estg_arith u_arith (
    .clk (clk),
    .ctl (arith_ctl),
    .res (arith_res)
  );

  // Arithmetic unit schedule
  always_comb begin
    arith_ctl.op       = OP_NONE;
    arith_ctl.mul_a    = MUL_A_W'(s_mag);
    arith_ctl.mul_b    = volume;
    arith_ctl.dividend = DIVIDEND_W'(envelope_remainder) + ENV_ONE;
    arith_ctl.divisor  = n_eff;
    unique case (state)
      S_MUL_VOL: begin
        arith_ctl.op = OP_MUL;
      end
      S_MUL_ENV: begin
        arith_ctl.op    = OP_MUL;
        arith_ctl.mul_a = arith_res.product[MUL_A_W-1:0];
        arith_ctl.mul_b = e_mag;
      end
      S_DIV_INIT: begin
        arith_ctl.op = OP_DIV_INIT;
      end
      S_DIVIDE: begin
        arith_ctl.op = OP_DIV_STEP;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.restart || running) ? S_LOOK_TONE : S_FINISH;
        end
      end
      S_LOOK_TONE: state_next = S_LOOK_ENV;
      S_LOOK_ENV:  state_next = S_MUL_VOL;
      S_MUL_VOL:   state_next = S_MUL_ENV;
      S_MUL_ENV:   state_next = S_DIV_INIT;
      S_DIV_INIT:  state_next = S_DIVIDE;
      S_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control, configuration and tone state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      phase_step         <= '0;
      sample_count       <= COUNT_BITS'(1);
      volume             <= '0;
      running            <= 1'b0;
      sample_index       <= '0;
      tone_phase         <= '0;
      envelope_phase     <= '0;
      envelope_remainder <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;

      if (wr_en) begin
        unique case (wr_index)
          REG_PHASE_STEP:   phase_step   <= wr_data;
          REG_SAMPLE_COUNT: sample_count <= wr_data[COUNT_BITS-1:0];
          REG_VOLUME:       volume       <= wr_data[VOLUME_W-1:0];
          default: begin
          end
        endcase
      end

      // restart takes effect before this request's sample
      if (state == S_IDLE && req.valid && req.restart) begin
        running            <= 1'b1;
        sample_index       <= '0;
        tone_phase         <= '0;
        envelope_phase     <= '0;
        envelope_remainder <= '0;
      end

      // commit the sample and advance the tone; otherwise drain on ready
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
        if (running) begin
          if (fin) begin
            running <= 1'b0;
          end else begin
            sample_index       <= sample_index + COUNT_BITS'(1);
            tone_phase         <= tone_phase + phase_step;
            envelope_phase     <= envelope_phase + arith_res.quotient;
            envelope_remainder <= arith_res.remainder;
          end
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOOK_TONE: begin
        look_peak <= sine_is_peak(tone_pt);
        s_neg     <= tone_pt.quad[1];
      end
      S_LOOK_ENV: begin
        s_mag     <= look_peak ? PEAK : rom_q;
        look_peak <= sine_is_peak(env_pt);
      end
      S_MUL_VOL: begin
        e_mag <= look_peak ? PEAK : rom_q;
      end
      S_DIV_INIT: begin
        div_cnt <= DIV_CNT_W'(DIVIDEND_W - 1);
      end
      S_DIVIDE: begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      S_FINISH: begin
        if (out_free) begin
          out_sample <= running ? signed'(pcm) : '0;
          out_last   <= running && fin;
          out_active <= running;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.sample = out_sample;
  assign rsp.last   = out_last;
  assign rsp.active = out_active;

  // One request in flight: no acceptance in the cycle after one
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one still in work");

  // Idle results are all zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.active) |-> (rsp.sample == '0 && !rsp.last))
    else $error("inactive result carries a sample or last flag");

  // Divider remainder stays below the tone length
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && running) |-> (arith_res.remainder < n_eff))
    else $error("envelope remainder not below sample count");

  // Final sample stops the tone
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free && running && fin) |=> (!running && rsp.last))
    else $error("tone still running after its last sample");

endmodule

/* rtl/estg_sine_rom.sv */
// Quarter-wave sine table with registered read data.
// Depends on estg_pkg for the table contents and sizing.
module estg_sine_rom (
  input  logic                             clk,
  input  logic [estg_pkg::SINE_ADDR_W-1:0] addr,
  output logic [estg_pkg::MAG_W-1:0]       q
);
  import estg_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Synchronous read
  always_ff @(posedge clk) begin
    q <= SINE_ROM[addr];
  end

endmodule

/* rtl/estg_arith.sv */
// Shared arithmetic unit: a 30x15 multiplier and a one-bit-per-cycle restoring divider.
// Depends on estg_pkg for the control and result structs.
module estg_arith (
  input  logic                 clk,
  input  estg_pkg::arith_ctl_t ctl,
  output estg_pkg::arith_res_t res
);
  import estg_pkg::*;

  logic [PROD_W-1:0]      product;
  logic [COUNT_BITS-1:0]  acc;
  logic [ENV_PHASE_W-1:0] quot;
  logic [DIVIDEND_W-1:0]  dvd;

  logic [COUNT_BITS:0]    trial;
  logic [COUNT_BITS:0]    diff;
  logic                   take;

  // Divider step: shift in the next dividend bit, subtract when it fits
  assign trial = {acc, dvd[DIVIDEND_W-1]};
  assign take  = trial >= {1'b0, ctl.divisor};
  assign diff  = trial - {1'b0, ctl.divisor};

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_MUL: begin
        product <= PROD_W'(ctl.mul_a) * PROD_W'(ctl.mul_b);
      end
      OP_DIV_INIT: begin
        acc  <= '0;
        quot <= '0;
        dvd  <= ctl.dividend;
      end
      OP_DIV_STEP: begin
        acc  <= take ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        // quotient bits above the envelope width fall off: wrap modulo 2^16
        quot <= {quot[ENV_PHASE_W-2:0], take};
        dvd  <= dvd << 1;
      end
      default: begin
      end
    endcase
  end

  assign res.product   = product;
  assign res.quotient  = quot;
  assign res.remainder = acc;

endmodule
